/* sv/bb_pkg.sv */
package bb_pkg;

    localparam int RING_DEPTH = 256;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int LEN_W      = RING_AW + 1;
    localparam int PRICE_W    = 24;
    localparam int SUM_W      = 32;
    localparam int SQ_W       = 56;
    localparam int MULT_W     = 16;
    localparam int ROOT_W     = 40;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int DIV_NW     = 64;
    localparam int DIV_DW     = 48;
    localparam int DEV_W      = 42;
    localparam int BAND_W     = 41;
    localparam int CFG_IW     = 1;
    localparam int CFG_DW     = 16;

    localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(20);
    localparam logic [MULT_W-1:0] MULT_RESET = MULT_W'(512);

    localparam logic [CFG_IW-1:0] REG_WINDOW_LENGTH   = 1'b0;
    localparam logic [CFG_IW-1:0] REG_BAND_MULTIPLIER = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_PRODUCT,
        ST_ROOT,
        ST_MEAN,
        ST_DEV,
        ST_BANDS,
        ST_WIDTH,
        ST_PCTB,
        ST_OUT
    } bb_state_t;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_NW-1:0] quo;
    } div_rsp_t;

    typedef struct packed {
        logic             start;
        logic [RAD_W-1:0] rad;
    } sqrt_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [ROOT_W-1:0] root;
    } sqrt_rsp_t;

endpackage

/* sv/bb_div.sv */
module bb_div (
    input  logic             aclk,
    input  logic             aresetn,
    input  bb_pkg::div_req_t req,
    output bb_pkg::div_rsp_t rsp
);
    import bb_pkg::*;

    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_NW-1:0] acc_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [DIV_DW:0]   rem_sh;
    logic              fits;

    assign rem_sh = {rem_reg, acc_reg[DIV_NW-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_NW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            acc_reg <= req.num;
            den_reg <= req.den;
        end else if (busy_reg) begin
            rem_reg <= fits ? DIV_DW'(rem_sh - {1'b0, den_reg}) : rem_sh[DIV_DW-1:0];
            acc_reg <= {acc_reg[DIV_NW-2:0], fits};
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = acc_reg;

endmodule

/* sv/bb_sqrt.sv */
module bb_sqrt (
    input  logic              aclk,
    input  logic              aresetn,
    input  bb_pkg::sqrt_req_t req,
    output bb_pkg::sqrt_rsp_t rsp
);
    import bb_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W + 1);
    localparam int REM_W = ROOT_W + 2;

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic              fits;

    assign rem_sh = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial  = (REM_W+2)'({root_reg, 2'b01});
    assign fits   = rem_sh >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rad_reg  <= req.rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= fits ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], fits};
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

endmodule

/* sv/bollinger_band_stream.sv */
// Bollinger band stream, population deviation, exact integer variance.
// Input channel s_*: one closing price per item, with a date tag and a
// restart flag that clears the window and the bar index before the item.
// Result channel m_*: one result per item: date, index, valid_res, mean,
// upper/lower band (Q.8), bandwidth and percent-B (Q16.16, saturating).
// Before the window holds window_length prices valid_res is 0, bands zero.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata, to be written while idle only
// (not enforced). Index 0 sets window_length from cfg_wdata[8:0], clamped
// to 1..256, clearing the window; index 1 sets band_multiplier (k, Q8.8).
// Sequence: an item that leaves the window short goes from the update step
// straight to the output step; a full window runs the product step, the
// square root and four divisions (mean, deviation, bandwidth, percent-B)
// sharing one radix-2 divider. The bandwidth division is skipped when the
// mean is zero, the percent-B division when the deviation is zero.
// One item is in work at a time; s_ready is high while the sequencer idles,
// also while a finished result waits in the output register.
// A stalled receiver holds the result; the next item runs up to its output
// step and waits there. Reset (aresetn low, synchronous) empties the
// window, zeroes the index and loads window_length 20 and k 2.0.
module bollinger_band_stream (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [bb_pkg::CFG_IW-1:0]           cfg_index,
    input  logic [bb_pkg::CFG_DW-1:0]           cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [bb_pkg::PRICE_W-1:0]          s_close_price,
    input  logic [31:0]                         s_bar_date,
    input  logic                                s_restart,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [31:0]                         m_bar_date_out,
    output logic [31:0]                         m_bar_index,
    output logic                                m_valid_res,
    output logic [31:0]                         m_middle_band,
    output logic signed [bb_pkg::BAND_W-1:0]    m_upper_band,
    output logic signed [bb_pkg::BAND_W-1:0]    m_lower_band,
    output logic [31:0]                         m_band_width,
    output logic signed [31:0]                  m_percent_b
);
    import bb_pkg::*;

    localparam int WIDE_W = DEV_W + 1;

    bb_state_t state_reg, state_next;
    logic      started_reg, started_next;

    logic [LEN_W-1:0]   win_len_reg;
    logic [MULT_W-1:0]  mult_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [SQ_W-1:0]    sq_reg;
    logic [LEN_W-1:0]   fill_reg;
    logic [RING_AW-1:0] slot_reg;
    logic [31:0]        counter_reg;

    logic [PRICE_W-1:0] ring_mem [RING_DEPTH];
    logic [PRICE_W-1:0] ring_q_reg;
    logic [RING_AW-1:0] rd_addr;

    logic [PRICE_W-1:0] price_reg;
    logic [31:0]        date_reg;
    logic [31:0]        idx_reg;
    logic               vres_reg;
    logic [63:0]        pl_reg;
    logic [63:0]        pss_reg;
    logic [ROOT_W-1:0]  s_reg;
    logic [SQ_W-1:0]    ks_reg;
    logic [31:0]        mean_reg;
    logic [DEV_W-1:0]   dev_reg;
    logic [BAND_W-1:0]  upper_reg;
    logic [BAND_W-1:0]  lower_reg;
    logic               pneg_reg;
    logic [WIDE_W-1:0]  pmag_reg;
    logic [31:0]        bw_reg;
    logic [31:0]        pb_reg;
    logic               m_valid_reg;

    logic               acc;
    logic               out_load;
    logic               full;
    logic               valid_now;
    logic [PRICE_W-1:0] old;
    logic [2*PRICE_W-1:0] old_sq;
    logic [2*PRICE_W-1:0] new_sq;
    logic [LEN_W-1:0]   len_in;
    logic [WIDE_W-1:0]  up_w;
    logic [WIDE_W-1:0]  lo_w;
    logic [WIDE_W-1:0]  pn_w;
    logic [31:0]        q_sat;

    div_req_t  div_req;
    div_rsp_t  div_rsp;
    sqrt_req_t sqrt_req;
    sqrt_rsp_t sqrt_rsp;

    bb_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    bb_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (sqrt_req),
        .rsp     (sqrt_rsp)
    );

    assign acc      = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    assign full      = (fill_reg == win_len_reg);
    assign valid_now = full || (LEN_W'(fill_reg + 1'b1) == win_len_reg);
    assign old       = full ? ring_q_reg : '0;
    assign old_sq    = old * old;
    assign new_sq    = price_reg * price_reg;
    assign rd_addr   = slot_reg - win_len_reg[RING_AW-1:0];

    assign up_w = WIDE_W'(mean_reg) + WIDE_W'(dev_reg);
    assign lo_w = WIDE_W'(mean_reg) - WIDE_W'(dev_reg);
    assign pn_w = WIDE_W'({price_reg, 8'b0}) - lo_w;

    always_comb begin
        len_in = cfg_wdata[LEN_W-1:0];
        if (len_in == '0) begin
            len_in = LEN_W'(1);
        end else if (len_in > LEN_W'(RING_DEPTH)) begin
            len_in = LEN_W'(RING_DEPTH);
        end
    end

    always_comb begin
        if (pneg_reg) begin
            q_sat = (div_rsp.quo > 64'h8000_0000) ? 32'h8000_0000 : div_rsp.quo[31:0];
            q_sat = 32'(0 - q_sat);
        end else begin
            q_sat = (div_rsp.quo > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_rsp.quo[31:0];
        end
    end

    always_comb begin
        state_next     = state_reg;
        started_next   = started_reg;
        div_req.start  = 1'b0;
        div_req.num    = '0;
        div_req.den    = '0;
        sqrt_req.start = 1'b0;
        sqrt_req.rad   = {pl_reg - pss_reg, 16'h0000};
        unique case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                state_next = valid_now ? ST_PRODUCT : ST_OUT;
            end
            ST_PRODUCT: begin
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                if (!started_reg) begin
                    sqrt_req.start = 1'b1;
                    started_next   = 1'b1;
                end else if (sqrt_rsp.done) begin
                    started_next = 1'b0;
                    state_next   = ST_MEAN;
                end
            end
            ST_MEAN: begin
                div_req.num = DIV_NW'({sum_reg, 8'b0}) + DIV_NW'(win_len_reg >> 1);
                div_req.den = DIV_DW'(win_len_reg);
                if (!started_reg) begin
                    div_req.start = 1'b1;
                    started_next  = 1'b1;
                end else if (div_rsp.done) begin
                    started_next = 1'b0;
                    state_next   = ST_DEV;
                end
            end
            ST_DEV: begin
                div_req.num = DIV_NW'(ks_reg) + DIV_NW'({win_len_reg, 7'b0});
                div_req.den = DIV_DW'({win_len_reg, 8'b0});
                if (!started_reg) begin
                    div_req.start = 1'b1;
                    started_next  = 1'b1;
                end else if (div_rsp.done) begin
                    started_next = 1'b0;
                    state_next   = ST_BANDS;
                end
            end
            ST_BANDS: begin
                state_next = ST_WIDTH;
            end
            ST_WIDTH: begin
                div_req.num = DIV_NW'({dev_reg, 17'b0}) + DIV_NW'(mean_reg >> 1);
                div_req.den = DIV_DW'(mean_reg);
                if (mean_reg == '0) begin
                    state_next = ST_PCTB;
                end else if (!started_reg) begin
                    div_req.start = 1'b1;
                    started_next  = 1'b1;
                end else if (div_rsp.done) begin
                    started_next = 1'b0;
                    state_next   = ST_PCTB;
                end
            end
            ST_PCTB: begin
                div_req.num = DIV_NW'({pmag_reg, 16'b0}) + DIV_NW'(dev_reg);
                div_req.den = DIV_DW'({dev_reg, 1'b0});
                if (dev_reg == '0) begin
                    state_next = ST_OUT;
                end else if (!started_reg) begin
                    div_req.start = 1'b1;
                    started_next  = 1'b1;
                end else if (div_rsp.done) begin
                    started_next = 1'b0;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            started_reg <= 1'b0;
            win_len_reg <= LEN_RESET;
            mult_reg    <= MULT_RESET;
            sum_reg     <= '0;
            sq_reg      <= '0;
            fill_reg    <= '0;
            slot_reg    <= '0;
            counter_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            started_reg <= started_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_WINDOW_LENGTH: begin
                        win_len_reg <= len_in;
                        sum_reg     <= '0;
                        sq_reg      <= '0;
                        fill_reg    <= '0;
                        slot_reg    <= '0;
                    end
                    REG_BAND_MULTIPLIER: begin
                        mult_reg <= cfg_wdata[MULT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end else if (acc) begin
                counter_reg <= (s_restart ? 32'd0 : counter_reg) + 32'd1;
                if (s_restart) begin
                    sum_reg  <= '0;
                    sq_reg   <= '0;
                    fill_reg <= '0;
                    slot_reg <= '0;
                end
            end else if (state_reg == ST_UPDATE) begin
                sum_reg  <= sum_reg - SUM_W'(old) + SUM_W'(price_reg);
                sq_reg   <= sq_reg - SQ_W'(old_sq) + SQ_W'(new_sq);
                fill_reg <= full ? fill_reg : LEN_W'(fill_reg + 1'b1);
                slot_reg <= slot_reg + 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ring: read at accept, write back in the update step; one item in flight
    always_ff @(posedge aclk) begin
        if (state_reg == ST_UPDATE) begin
            ring_mem[slot_reg] <= price_reg;
        end
        ring_q_reg <= ring_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            price_reg <= s_close_price;
            date_reg  <= s_bar_date;
            idx_reg   <= s_restart ? 32'd0 : counter_reg;
        end
        unique case (state_reg)
            ST_UPDATE: begin
                vres_reg <= valid_now;
                if (!valid_now) begin
                    mean_reg  <= '0;
                    upper_reg <= '0;
                    lower_reg <= '0;
                    bw_reg    <= '0;
                    pb_reg    <= '0;
                end
            end
            ST_PRODUCT: begin
                pl_reg  <= 64'(win_len_reg) * 64'(sq_reg);
                pss_reg <= sum_reg * sum_reg;
            end
            ST_ROOT: begin
                if (started_reg && sqrt_rsp.done) begin
                    s_reg <= sqrt_rsp.root;
                end
            end
            ST_MEAN: begin
                ks_reg <= mult_reg * s_reg;
                if (started_reg && div_rsp.done) begin
                    mean_reg <= div_rsp.quo[31:0];
                end
            end
            ST_DEV: begin
                if (started_reg && div_rsp.done) begin
                    dev_reg <= div_rsp.quo[DEV_W-1:0];
                end
            end
            ST_BANDS: begin
                upper_reg <= up_w[BAND_W-1:0];
                lower_reg <= lo_w[BAND_W-1:0];
                pneg_reg  <= pn_w[WIDE_W-1];
                pmag_reg  <= pn_w[WIDE_W-1] ? WIDE_W'(0 - pn_w) : pn_w;
            end
            ST_WIDTH: begin
                if (mean_reg == '0) begin
                    bw_reg <= '0;
                end else if (started_reg && div_rsp.done) begin
                    bw_reg <= (div_rsp.quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                            : div_rsp.quo[31:0];
                end
            end
            ST_PCTB: begin
                if (dev_reg == '0) begin
                    pb_reg <= '0;
                end else if (started_reg && div_rsp.done) begin
                    pb_reg <= q_sat;
                end
            end
            default: begin
            end
        endcase
        if (out_load) begin
            m_bar_date_out <= date_reg;
            m_bar_index    <= idx_reg;
            m_valid_res    <= vres_reg;
            m_middle_band  <= mean_reg;
            m_upper_band   <= upper_reg;
            m_lower_band   <= lower_reg;
            m_band_width   <= bw_reg;
            m_percent_b    <= pb_reg;
        end
    end

    assign m_valid = m_valid_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= win_len_reg)
        else $error("fill count above window length");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_valid_res |-> m_middle_band == '0 && m_band_width == '0
            && m_percent_b == '0 && m_upper_band == '0)
        else $error("short-window result carries band values");

    a_idle_units: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !div_rsp.busy && !sqrt_rsp.busy)
        else $error("arithmetic unit busy while idle");

    a_accept_update: assert property (@(posedge aclk) disable iff (!aresetn)
        acc && !cfg_wr_en |=> state_reg == ST_UPDATE)
        else $error("accepted item did not reach update");

endmodule
